// ===== src/lcv3_pkg.sv =====
package lcv3_pkg;

    // Fixed field widths of the stream.
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned CNT_W  = 11;
    localparam int unsigned SIZE_W = 12;
    localparam int unsigned VAL_W  = 17;

    // Window sums: nine pixels and nine squares.
    localparam int unsigned SUM_W  = 12;
    localparam int unsigned SQ_W   = 20;
    localparam int unsigned DIFF_W = 24;

    // (100 * 256)^2, the scale applied under the square root.
    localparam int unsigned SCALE_W  = 30;
    localparam logic [SCALE_W-1:0] SCALE_SQ = 30'd655360000;

    // Radicand, root and root remainder widths.
    localparam int unsigned RAD_W  = 54;
    localparam int unsigned ROOT_W = 27;
    localparam int unsigned REM_W  = ROOT_W + 3;
    localparam int unsigned STEP_W = 5;

    // Line store depth; the column counter covers exactly this many columns.
    localparam int unsigned MAX_WIDTH  = 2048;
    localparam int unsigned MAX_HEIGHT = 2048;
    localparam int unsigned MIN_SIZE   = 3;

    // Configuration register indexes.
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_SUM,
        S_DIFF,
        S_SCALE,
        S_ROOT,
        S_DIVIDE,
        S_DONE
    } t_state;

endpackage

// ===== src/local_coefficient_of_variation_3x3.sv =====
// Channel     Direction  Accepted when                       Payload
// s_axis      in         i_s_axis_tvalid & o_s_axis_tready    tdata: pixel; tuser: frame_start
// m_axis      out        o_m_axis_tvalid & i_m_axis_tready    tdata: value,row,col; tlast
// cfg         in         i_cfg_we                             index 0 width, 1 height
//
// An item that gives no result (a border centre) passes through the accept cycle, in
// which both line stores are read, and S_FETCH, in which the window shifts and the stores
// are written back. An interior item goes on through the sums and scaling (S_SUM, S_DIFF,
// S_SCALE), the bit-serial square root, the bit-serial division and S_DONE, which hands
// the result to the output register; the two serial loops set the rate. An all-zero
// window skips both loops.
// Reset (synchronous, active low) clears counters, window and control; the line stores
// keep no reset and are filled by the first two rows of a frame. The finished result sits
// in the output register, so the next item is taken while it waits for the consumer; only
// a second result meeting a still-full output register stalls the block.
module local_coefficient_of_variation_3x3 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] pixel
    input  logic        i_s_axis_tuser,   // [0] frame_start
    // Output stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [16:0] variation_value, [27:17] center_row,
                                          // [38:28] center_col, [39] zero
    output logic        o_m_axis_tlast,   // frame_last
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    localparam int unsigned AW = $clog2(lcv3_pkg::MAX_WIDTH);
    localparam int unsigned GW = 14;
    localparam logic [GW-1:0] MAXW = GW'(lcv3_pkg::MAX_WIDTH);

    // Line stores: one pixel per column for each of the two rows above.
    logic [lcv3_pkg::PIX_W-1:0] mem_up  [lcv3_pkg::MAX_WIDTH];
    logic [lcv3_pkg::PIX_W-1:0] mem_mid [lcv3_pkg::MAX_WIDTH];

    lcv3_pkg::t_state r_state, n_state;

    logic [lcv3_pkg::SIZE_W-1:0] r_width, r_height;
    logic [lcv3_pkg::CNT_W-1:0]  r_col, r_row;
    logic [lcv3_pkg::PIX_W-1:0]  r_win [9];

    logic [lcv3_pkg::PIX_W-1:0]  r_px, r_up_q, r_mid_q;
    logic [AW-1:0]               r_idx;
    logic                        r_interior, r_last;
    logic [lcv3_pkg::CNT_W-1:0]  r_crow, r_ccol;

    logic [lcv3_pkg::SUM_W-1:0]  r_s;
    logic [lcv3_pkg::SQ_W-1:0]   r_q;
    logic [lcv3_pkg::DIFF_W-1:0] r_d;
    logic [lcv3_pkg::RAD_W-1:0]  r_rad;
    logic [lcv3_pkg::REM_W-1:0]  r_rem;
    logic [lcv3_pkg::ROOT_W-1:0] r_root;
    logic [lcv3_pkg::SUM_W-1:0]  r_drem;
    logic [lcv3_pkg::STEP_W-1:0] r_step;
    logic [lcv3_pkg::VAL_W-1:0]  r_val;

    logic                        r_out_valid;
    logic [39:0]                 r_out_data;
    logic                        r_out_last;

    // Control strobes.
    logic accept, load_out;

    // Counter and address logic for the item at the input.
    logic [lcv3_pkg::CNT_W-1:0] cur_col, cur_row, n_col, n_row;
    logic [GW-1:0] eff_w, eff_h, col_x, row_x;
    logic [31:0]   idx_x;
    logic [AW-1:0] cur_idx;

    always_comb begin
        eff_w = GW'(r_width);
        if (eff_w < GW'(lcv3_pkg::MIN_SIZE)) begin
            eff_w = GW'(lcv3_pkg::MIN_SIZE);
        end else if (eff_w > MAXW) begin
            eff_w = MAXW;
        end
        eff_h = GW'(r_height);
        if (eff_h < GW'(lcv3_pkg::MIN_SIZE)) begin
            eff_h = GW'(lcv3_pkg::MIN_SIZE);
        end else if (eff_h > GW'(lcv3_pkg::MAX_HEIGHT)) begin
            eff_h = GW'(lcv3_pkg::MAX_HEIGHT);
        end
        cur_col = i_s_axis_tuser ? '0 : r_col;
        cur_row = i_s_axis_tuser ? '0 : r_row;
        col_x   = GW'(cur_col);
        row_x   = GW'(cur_row);
        idx_x   = 32'(cur_col);
        cur_idx = idx_x[AW-1:0];
        // Wrap the column at the row end and the row at the frame end.
        if (col_x + GW'(1) >= eff_w) begin
            n_col = '0;
            n_row = (row_x + GW'(1) >= eff_h) ? '0 : cur_row + 1'b1;
        end else begin
            n_col = cur_col + 1'b1;
            n_row = cur_row;
        end
    end

    // Window sums.
    logic [lcv3_pkg::SUM_W-1:0] win_s;
    logic [lcv3_pkg::SQ_W-1:0]  win_q;

    always_comb begin
        win_s = '0;
        win_q = '0;
        for (int i = 0; i < 9; i++) begin
            win_s = win_s + lcv3_pkg::SUM_W'(r_win[i]);
            win_q = win_q + lcv3_pkg::SQ_W'(r_win[i]) * lcv3_pkg::SQ_W'(r_win[i]);
        end
    end

    // One step of the digit-by-digit square root.
    logic [lcv3_pkg::REM_W-1:0] rt_sh, rt_trial;
    logic                       rt_ge;

    always_comb begin
        rt_sh    = {r_rem[lcv3_pkg::REM_W-3:0], r_rad[lcv3_pkg::RAD_W-1 -: 2]};
        rt_trial = {1'b0, r_root, 2'b01};
        rt_ge    = rt_sh >= rt_trial;
    end

    // One step of the restoring division of the root by the sum.
    logic [lcv3_pkg::SUM_W:0] dv_sh, dv_diff;
    logic                     dv_ge;

    always_comb begin
        dv_sh   = {r_drem, r_root[lcv3_pkg::ROOT_W-1]};
        dv_diff = dv_sh - {1'b0, r_s};
        dv_ge   = dv_sh >= {1'b0, r_s};
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lcv3_pkg::S_IDLE:   if (i_s_axis_tvalid) n_state = lcv3_pkg::S_FETCH;
            lcv3_pkg::S_FETCH:  n_state = r_interior ? lcv3_pkg::S_SUM : lcv3_pkg::S_IDLE;
            lcv3_pkg::S_SUM:    n_state = lcv3_pkg::S_DIFF;
            lcv3_pkg::S_DIFF:   n_state = (r_s == '0) ? lcv3_pkg::S_DONE : lcv3_pkg::S_SCALE;
            lcv3_pkg::S_SCALE:  n_state = lcv3_pkg::S_ROOT;
            lcv3_pkg::S_ROOT:   if (r_step == '0) n_state = lcv3_pkg::S_DIVIDE;
            lcv3_pkg::S_DIVIDE: if (r_step == '0) n_state = lcv3_pkg::S_DONE;
            lcv3_pkg::S_DONE:   if (load_out) n_state = lcv3_pkg::S_IDLE;
            default:            n_state = lcv3_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer. No item is taken while reset is held.
    always_comb begin
        o_s_axis_tready = 1'b0;
        load_out        = 1'b0;
        case (r_state)
            lcv3_pkg::S_IDLE: o_s_axis_tready = i_rst_n;
            lcv3_pkg::S_DONE: load_out = !r_out_valid || i_m_axis_tready;
            default: ;
        endcase
        accept = o_s_axis_tready && i_s_axis_tvalid;
    end

    // Line store reads at accept, write-back once the old entries are in hand.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up_q  <= mem_up[cur_idx];
            r_mid_q <= mem_mid[cur_idx];
        end
        if (r_state == lcv3_pkg::S_FETCH) begin
            mem_up[r_idx]  <= r_mid_q;
            mem_mid[r_idx] <= r_px;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcv3_pkg::S_IDLE;
            r_width     <= 12'd640;
            r_height    <= 12'd480;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lcv3_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                    lcv3_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (r_state == lcv3_pkg::S_FETCH) begin
                // Rows are upper, middle, current; the new column enters on the right.
                for (int i = 0; i < 3; i++) begin
                    r_win[3*i]     <= r_win[3*i + 1];
                    r_win[3*i + 1] <= r_win[3*i + 2];
                end
                r_win[2] <= r_up_q;
                r_win[5] <= r_mid_q;
                r_win[8] <= r_px;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px       <= i_s_axis_tdata;
            r_idx      <= cur_idx;
            r_interior <= (cur_row >= 11'd2) && (cur_col >= 11'd2);
            r_last     <= (row_x == eff_h - GW'(1)) && (col_x == eff_w - GW'(1));
            r_crow     <= cur_row - 1'b1;
            r_ccol     <= cur_col - 1'b1;
        end
        case (r_state)
            lcv3_pkg::S_SUM: begin
                r_s <= win_s;
                r_q <= win_q;
            end
            lcv3_pkg::S_DIFF: begin
                r_d   <= lcv3_pkg::DIFF_W'(r_q) * lcv3_pkg::DIFF_W'(9)
                         - lcv3_pkg::DIFF_W'(r_s) * lcv3_pkg::DIFF_W'(r_s);
                r_val <= '0;
            end
            lcv3_pkg::S_SCALE: begin
                r_rad  <= lcv3_pkg::RAD_W'(r_d) * lcv3_pkg::RAD_W'(lcv3_pkg::SCALE_SQ);
                r_rem  <= '0;
                r_root <= '0;
                r_step <= lcv3_pkg::STEP_W'(lcv3_pkg::ROOT_W - 1);
            end
            lcv3_pkg::S_ROOT: begin
                r_rad  <= {r_rad[lcv3_pkg::RAD_W-3:0], 2'b00};
                r_rem  <= rt_ge ? rt_sh - rt_trial : rt_sh;
                r_root <= {r_root[lcv3_pkg::ROOT_W-2:0], rt_ge};
                r_drem <= '0;
                r_step <= (r_step == '0) ? lcv3_pkg::STEP_W'(lcv3_pkg::ROOT_W - 1)
                                         : r_step - 1'b1;
            end
            lcv3_pkg::S_DIVIDE: begin
                // The dividend shifts out of the top of the root register while
                // quotient bits shift in at the bottom.
                r_drem <= dv_ge ? dv_diff[lcv3_pkg::SUM_W-1:0] : dv_sh[lcv3_pkg::SUM_W-1:0];
                r_root <= {r_root[lcv3_pkg::ROOT_W-2:0], dv_ge};
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_val <= {r_root[lcv3_pkg::VAL_W-2:0], dv_ge};
                end
            end
            default: ;
        endcase
        if (load_out) begin
            r_out_data <= {1'b0, r_ccol, r_crow, r_val};
            r_out_last <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== sim/tb_local_coefficient_of_variation_3x3.sv =====
module tb_local_coefficient_of_variation_3x3;

    // The drain slack is long enough for a result to be released after its item.
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT  = 3000000;

    // One expected window result, in the order of the output fields.
    typedef struct packed {
        logic [lcv3_pkg::VAL_W-1:0] value;
        logic [lcv3_pkg::CNT_W-1:0] row;
        logic [lcv3_pkg::CNT_W-1:0] col;
        logic                       last;
    } t_cv_result;

    // The scoreboard keeps its own copy of the raster state and turns every
    // accepted pixel into the result that the block has to produce for it.
    class cv_scoreboard;
        logic [lcv3_pkg::PIX_W-1:0]  upper_row [2048];
        logic [lcv3_pkg::PIX_W-1:0]  middle_row [2048];
        logic [lcv3_pkg::PIX_W-1:0]  win [9];
        int unsigned       col_count;
        int unsigned       row_count;
        int unsigned       width_reg;
        int unsigned       height_reg;
        t_cv_result        pending[$];
        int unsigned       errors;

        function new();
            foreach (upper_row[i]) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            col_count  = 0;
            row_count  = 0;
            width_reg  = 640;
            height_reg = 480;
            errors     = 0;
        endfunction

        function void write_reg(logic index, logic [lcv3_pkg::SIZE_W-1:0] data);
            if (index == lcv3_pkg::CFG_WIDTH) width_reg = 32'(data);
            else height_reg = 32'(data);
        endfunction

        // Sizes below three or above the store depth are clamped.
        function int unsigned clamp(int unsigned v);
            if (v < lcv3_pkg::MIN_SIZE) return lcv3_pkg::MIN_SIZE;
            if (v > lcv3_pkg::MAX_HEIGHT) return lcv3_pkg::MAX_HEIGHT;
            return v;
        endfunction

        // floor(25600 * sqrt(d) / s), found bit by bit from the top of the
        // result so that no rounding of a real square root creeps in.
        function logic [lcv3_pkg::VAL_W-1:0] scaled_cv(longint unsigned d,
                                                        longint unsigned s);
            longint unsigned goal;
            longint unsigned r;
            longint unsigned t;
            longint unsigned p;
            goal = longint'(lcv3_pkg::SCALE_SQ) * d;
            r = 0;
            for (int b = lcv3_pkg::VAL_W - 1; b >= 0; b--) begin
                t = r | (64'd1 << b);
                p = t * s;
                if (p * p <= goal) r = t;
            end
            return r[lcv3_pkg::VAL_W-1:0];
        endfunction

        function void note_pixel(logic [lcv3_pkg::PIX_W-1:0] px, logic frame_start);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            longint unsigned s;
            longint unsigned q;
            t_cv_result res;
            w = clamp(width_reg);
            h = clamp(height_reg);
            if (frame_start) begin
                col_count = 0;
                row_count = 0;
            end
            c = col_count;
            r = row_count;
            // The window moves one column left; the new column comes from the
            // two stored rows and the incoming pixel.
            for (int i = 0; i < 3; i++) begin
                win[3*i]   = win[3*i+1];
                win[3*i+1] = win[3*i+2];
            end
            win[2] = upper_row[c % 2048];
            win[5] = middle_row[c % 2048];
            win[8] = px;
            upper_row[c % 2048]  = middle_row[c % 2048];
            middle_row[c % 2048] = px;
            if (r >= 2 && c >= 2) begin
                s = 0;
                q = 0;
                foreach (win[i]) begin
                    s += win[i];
                    q += win[i] * win[i];
                end
                res.value = (s == 0) ? '0 : scaled_cv(9 * q - s * s, s);
                res.row   = lcv3_pkg::CNT_W'(r - 1);
                res.col   = lcv3_pkg::CNT_W'(c - 1);
                res.last  = (r == h - 1) && (c == w - 1);
                pending = {pending, res};
            end
            // Counters wrap at the row end and at the frame end.
            if (c + 1 >= w) begin
                col_count = 0;
                row_count = (r + 1 >= h) ? 0 : ((r + 1) & 11'h7FF);
            end else begin
                col_count = (c + 1) & 11'h7FF;
            end
        endfunction

        function void check_result(logic [39:0] data, logic last);
            t_cv_result exp_res;
            t_cv_result got;
            got = {data[16:0], data[27:17], data[38:28], last};
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (got.value !== exp_res.value) begin
                $display("%0t: variation_value expected %0d actual %0d",
                    $time, exp_res.value, got.value);
                errors++;
            end
            if (got.row !== exp_res.row) begin
                $display("%0t: center_row expected %0d actual %0d", $time, exp_res.row, got.row);
                errors++;
            end
            if (got.col !== exp_res.col) begin
                $display("%0t: center_col expected %0d actual %0d", $time, exp_res.col, got.col);
                errors++;
            end
            if (got.last !== exp_res.last) begin
                $display("%0t: frame_last expected %0b actual %0b", $time, exp_res.last, got.last);
                errors++;
            end
            if (data[39] !== 1'b0) begin
                $display("%0t: pad bit expected 0 actual %b", $time, data[39]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = lcv3_pkg::CFG_WIDTH;
    logic [11:0] i_cfg_data = '0;

    cv_scoreboard sb = new();
    int unsigned  send_idle = 0;    // percent of cycles the sender holds back
    int unsigned  recv_idle = 0;    // percent of cycles the receiver stalls
    int unsigned  cycle_count = 0;
    int unsigned  width_now;
    int unsigned  height_now;

    local_coefficient_of_variation_3x3 DUT (.*);

    always #5 i_clk = ~i_clk;

    // Results are checked at the rising edge on the values held before it.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("local_coefficient_of_variation_3x3 test failed");
            $finish;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tlast);
    end

    // The receiver decides at every falling edge whether to stall.
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_pixel(input logic [7:0] px, input logic frame_start);
        while ($urandom_range(99) < send_idle) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = px;
        i_s_axis_tuser  = frame_start;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_pixel(px, frame_start);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    // Waits until every expected result is out, then lets the block settle
    // so that a register write never meets an item still in flight.
    task automatic wait_drained();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic [11:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        sb.write_reg(index, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Half of the pixels come from the full range; the others are near black or
    // constant so that low means and flat windows show up often.
    function automatic logic [7:0] random_pixel();
        case ($urandom_range(3))
            0: return 8'($urandom_range(3));
            1: return 8'd200;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames of the smallest size. Width 0 and height 1 both
        // clamp up to three. The first frame holds one bright pixel among
        // zeros, which gives the largest value; the next two follow through
        // the counter wrap without a frame start: all black (zero mean),
        // then all white (zero spread).
        send_idle = 32;
        recv_idle = 50;
        write_reg(lcv3_pkg::CFG_WIDTH, 12'd0);
        write_reg(lcv3_pkg::CFG_HEIGHT, 12'd1);
        for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd255 : 8'd0, i == 0);
        for (int i = 0; i < 9; i++) send_pixel(8'd0, 1'b0);
        for (int i = 0; i < 9; i++) send_pixel(8'd255, 1'b0);
        wait_drained();

        // A height of all ones clamps to the row limit: a few rows of a very
        // tall, narrow frame.
        send_idle = 0;
        recv_idle = 0;
        write_reg(lcv3_pkg::CFG_WIDTH, 12'd3);
        write_reg(lcv3_pkg::CFG_HEIGHT, 12'hFFF);
        for (int i = 0; i < 90; i++) send_pixel(random_pixel(), i == 0);
        wait_drained();

        // Random part in three idling phases, small frames. Each phase starts
        // a new frame; now and then a frame start arrives in mid-frame.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 32 : (phase == 1) ? 50 : 0;
            recv_idle = (phase == 0) ? 50 : (phase == 1) ? 32 : 0;
            width_now  = $urandom_range(8, 3);
            height_now = $urandom_range(6, 3);
            write_reg(lcv3_pkg::CFG_WIDTH, 12'(width_now));
            write_reg(lcv3_pkg::CFG_HEIGHT, 12'(height_now));
            for (int i = 0; i < 145; i++)
                send_pixel(random_pixel(), (i == 0) || ($urandom_range(99) < 3));
            wait_drained();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("local_coefficient_of_variation_3x3 test passed");
        else
            $display("local_coefficient_of_variation_3x3 test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/lcv3_pkg.sv
src/local_coefficient_of_variation_3x3.sv
sim/tb_local_coefficient_of_variation_3x3.sv
